[hw/rtl/twel_pkg.sv]
// shared types and command codes for the timestamp window event log
package twel_pkg;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_PRUNE
    } twel_state_t;

    typedef logic [1:0] twel_cmd_t;

    localparam twel_cmd_t CMD_RECORD = 2'd0;
    localparam twel_cmd_t CMD_PRUNE  = 2'd1;
    localparam twel_cmd_t CMD_CLEAR  = 2'd2;

    localparam int unsigned PORT_TIME_BITS = 32;
    localparam int unsigned COUNT_BITS     = 7;

endpackage

[hw/rtl/twel_store.sv]
// timestamp ring storage: one write port, one registered read port
module twel_store #(
    parameter int unsigned DEPTH     = 64,
    parameter int unsigned ADDR_BITS = 6,
    parameter int unsigned DATA_BITS = 32
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/timestamp_window_event_log_top.sv]
// top level of the timestamp window event log
//
// Usage: each item on the item channel (command, now_seconds) is taken when
// item_valid is high and item_stall is low, and gives exactly one result on
// the result channel (event_count, dropped, pruned), taken when result_valid
// is high and result_stall is low. Commands: record appends now_seconds,
// prune drops the oldest entry once it is older than the window, clear
// empties the log, code 3 does nothing. The user must write the window
// through cfg_write_en / cfg_write_data only while the block is idle; the
// block itself does not enforce this. Record, clear, no-op and prune of an
// empty log show their result in the cycle after the item is taken and take
// one item per cycle while the result register is not stalled; a prune of a
// non-empty log first reads the oldest timestamp through the registered read
// port of the store, then registers its result from ST_PRUNE, where it holds
// item_stall high. Reset empties the log and sets the window to 60; memory
// contents are not cleared, since only held entries are ever read. While the
// result register holds an item that is stalled, item_stall is raised and
// nothing is lost.
module timestamp_window_event_log_top #(
    parameter int unsigned EVENT_SLOTS = 64,
    parameter int unsigned TIME_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  command,
    input  logic [31:0] now_seconds,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [6:0]  event_count,
    output logic        dropped,
    output logic        pruned
);

    localparam int unsigned SLOT_BITS  = $clog2(EVENT_SLOTS);
    localparam int unsigned CNT_BITS   = $clog2(EVENT_SLOTS + 1);
    localparam int unsigned SUM_BITS   = SLOT_BITS + 1;
    localparam int unsigned STORE_BITS =
        (TIME_BITS < twel_pkg::PORT_TIME_BITS) ? TIME_BITS : twel_pkg::PORT_TIME_BITS;
    localparam logic [CNT_BITS-1:0]  FULL_COUNT = CNT_BITS'(EVENT_SLOTS);
    localparam logic [SLOT_BITS-1:0] LAST_SLOT  = SLOT_BITS'(EVENT_SLOTS - 1);
    localparam logic [SUM_BITS-1:0]  SLOTS_SUM  = SUM_BITS'(EVENT_SLOTS);

    twel_pkg::twel_state_t state_reg;
    twel_pkg::twel_state_t state_next;

    logic [31:0]            window_reg;
    logic [SLOT_BITS-1:0]   oldest_reg;
    logic [SLOT_BITS-1:0]   oldest_next;
    logic [CNT_BITS-1:0]    count_reg;
    logic [CNT_BITS-1:0]    count_next;
    logic [STORE_BITS-1:0]  limit_reg;
    logic                   limit_ok_reg;
    logic                   result_valid_reg;
    logic                   result_valid_next;
    logic [CNT_BITS-1:0]    res_count_reg;
    logic [CNT_BITS-1:0]    res_count_next;
    logic                   dropped_reg;
    logic                   dropped_next;
    logic                   pruned_reg;
    logic                   pruned_next;

    logic                   accept;
    logic                   full;
    logic                   empty;
    logic                   mem_wr_en;
    logic                   mem_rd_en;
    logic                   res_load;
    logic                   expired;
    logic [SLOT_BITS-1:0]   tail_slot;
    logic [SLOT_BITS-1:0]   oldest_inc;
    logic [SUM_BITS-1:0]    tail_sum;
    logic [STORE_BITS-1:0]  now_masked;
    logic [STORE_BITS-1:0]  win_masked;
    logic [STORE_BITS-1:0]  head_time;

    assign full       = (count_reg == FULL_COUNT);
    assign empty      = (count_reg == '0);
    assign now_masked = now_seconds[STORE_BITS-1:0];
    assign win_masked = window_reg[STORE_BITS-1:0];
    assign tail_sum   = SUM_BITS'(oldest_reg) + SUM_BITS'(count_reg);
    assign tail_slot  = (tail_sum >= SLOTS_SUM) ? SLOT_BITS'(tail_sum - SLOTS_SUM)
                                                : SLOT_BITS'(tail_sum);
    assign oldest_inc = (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + SLOT_BITS'(1);
    assign expired    = limit_ok_reg && (limit_reg > head_time);

    twel_store #(
        .DEPTH     (EVENT_SLOTS),
        .ADDR_BITS (SLOT_BITS),
        .DATA_BITS (STORE_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (tail_slot),
        .wr_data (now_masked),
        .rd_en   (mem_rd_en),
        .rd_addr (oldest_reg),
        .rd_data (head_time)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            twel_pkg::ST_IDLE:
            begin
                if (item_valid && !item_stall && command == twel_pkg::CMD_PRUNE && !empty)
                begin
                    state_next = twel_pkg::ST_PRUNE;
                end
            end
            twel_pkg::ST_PRUNE:
            begin
                state_next = twel_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = twel_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        item_stall = 1'b1;
        unique case (state_reg)
            twel_pkg::ST_IDLE:
            begin
                item_stall = result_valid_reg && result_stall;
            end
            twel_pkg::ST_PRUNE:
            begin
                item_stall = 1'b1;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    assign accept = item_valid && !item_stall;

    // command decode and result build
    always_comb
    begin
        mem_wr_en      = 1'b0;
        mem_rd_en      = 1'b0;
        res_load       = 1'b0;
        count_next     = count_reg;
        oldest_next    = oldest_reg;
        res_count_next = res_count_reg;
        dropped_next   = dropped_reg;
        pruned_next    = pruned_reg;
        if (state_reg == twel_pkg::ST_PRUNE)
        begin
            res_load     = 1'b1;
            dropped_next = 1'b0;
            pruned_next  = expired;
            if (expired)
            begin
                count_next  = count_reg - CNT_BITS'(1);
                oldest_next = oldest_inc;
            end
        end
        else if (accept)
        begin
            dropped_next = 1'b0;
            pruned_next  = 1'b0;
            unique case (command)
                twel_pkg::CMD_RECORD:
                begin
                    res_load = 1'b1;
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        mem_wr_en  = 1'b1;
                        count_next = count_reg + CNT_BITS'(1);
                    end
                end
                twel_pkg::CMD_PRUNE:
                begin
                    mem_rd_en = !empty;
                    res_load  = empty;
                end
                twel_pkg::CMD_CLEAR:
                begin
                    res_load    = 1'b1;
                    count_next  = '0;
                    oldest_next = '0;
                end
                default:
                begin
                    res_load = 1'b1;
                end
            endcase
        end
        if (res_load)
        begin
            res_count_next = count_next;
        end
    end

    always_comb
    begin
        if (res_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= twel_pkg::ST_IDLE;
            window_reg       <= 32'd60;
            oldest_reg       <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            oldest_reg       <= oldest_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write_en)
            begin
                window_reg <= cfg_write_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_count_reg <= res_count_next;
        dropped_reg   <= dropped_next;
        pruned_reg    <= pruned_next;
        if (mem_rd_en)
        begin
            limit_ok_reg <= (now_masked >= win_masked);
            limit_reg    <= now_masked - win_masked;
        end
    end

    assign result_valid = result_valid_reg;
    assign event_count  = twel_pkg::COUNT_BITS'(res_count_reg);
    assign dropped      = dropped_reg;
    assign pruned       = pruned_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("event count above slot count");

    a_prune_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == twel_pkg::ST_PRUNE |=> state_reg == twel_pkg::ST_IDLE && result_valid_reg)
        else $error("prune did not finish in one cycle");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(dropped_reg && pruned_reg))
        else $error("dropped and pruned both set");

    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && dropped_reg |-> full)
        else $error("record dropped while log not full");

    a_prune_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == twel_pkg::ST_PRUNE && expired
        |=> count_reg == $past(count_reg) - CNT_BITS'(1))
        else $error("prune did not remove one entry");
`endif

endmodule

[tb/timestamp_window_event_log_top_tb.sv]
// testbench for the timestamp window event log: predictor scoreboard, random traffic and stalls
`timescale 1ns / 100ps

module timestamp_window_event_log_top_tb;

    localparam twel_pkg::twel_cmd_t CMD_NOOP = 2'd3;
    localparam int unsigned LOG_DEPTH = 64;
    localparam int unsigned PHASE_ITEMS = 115;

    typedef struct packed {
        logic [twel_pkg::COUNT_BITS-1:0] count;
        logic                            dropped;
        logic                            pruned;
    } log_result_t;

    class event_log_scoreboard;
        logic [twel_pkg::PORT_TIME_BITS-1:0] stamps [LOG_DEPTH];
        logic [5:0]                          head;
        logic [twel_pkg::COUNT_BITS-1:0]     held;
        logic [31:0]                         window;
        log_result_t                         due_q [$];
        int                                  errors;
        int                                  items;
        int                                  results;
        int                                  drops;
        int                                  prunes;

        function new();
            head    = '0;
            held    = '0;
            window  = 32'd60;
            errors  = 0;
            items   = 0;
            results = 0;
            drops   = 0;
            prunes  = 0;
        endfunction

        function void set_window(logic [31:0] w);
            window = w;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task note_item(twel_pkg::twel_cmd_t cmd, logic [twel_pkg::PORT_TIME_BITS-1:0] now);
            log_result_t r;
            logic [5:0]  slot;
            r = '0;
            items++;
            case (cmd)
                twel_pkg::CMD_RECORD:
                begin
                    if (held >= LOG_DEPTH)
                    begin
                        r.dropped = 1'b1;
                    end
                    else
                    begin
                        slot = head + held[5:0];
                        stamps[slot] = now;
                        held++;
                    end
                end
                twel_pkg::CMD_PRUNE:
                begin
                    if (held != 0 && now >= window && (now - window) > stamps[head])
                    begin
                        head++;
                        held--;
                        r.pruned = 1'b1;
                    end
                end
                twel_pkg::CMD_CLEAR:
                begin
                    held = '0;
                    head = '0;
                end
                default:
                begin
                end
            endcase
            r.count = held;
            due_q.push_back(r);
        endtask

        task check_result(logic [twel_pkg::COUNT_BITS-1:0] count, logic drop_flag,
                          logic prune_flag);
            log_result_t want;
            results++;
            drops  += drop_flag;
            prunes += prune_flag;
            if (due_q.size() == 0)
            begin
                report_mismatch("result with nothing expected, count", count, 0);
            end
            else
            begin
                want = due_q.pop_front();
                if (count !== want.count)
                    report_mismatch("event_count", count, want.count);
                if (drop_flag !== want.dropped)
                    report_mismatch("dropped", drop_flag, want.dropped);
                if (prune_flag !== want.pruned)
                    report_mismatch("pruned", prune_flag, want.pruned);
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [31:0]           cfg_write_data;
    logic                  item_valid;
    logic                  item_stall;
    logic [1:0]            command;
    logic [31:0]           now_seconds;
    logic                  result_valid;
    logic                  result_stall;
    logic [6:0]            event_count;
    logic                  dropped;
    logic                  pruned;

    event_log_scoreboard   sb;
    bit                    gaps_on;
    bit                    stall_on;
    int                    stall_left;
    logic                  stall_next;
    int                    window_count;

    timestamp_window_event_log_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .command        (command),
        .now_seconds    (now_seconds),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .event_count    (event_count),
        .dropped        (dropped),
        .pruned         (pruned)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result(event_count, dropped, pruned);
            if (item_valid && !item_stall)
                sb.note_item(twel_pkg::twel_cmd_t'(command), now_seconds);
        end
    end

    // receiver stall bursts
    always @(negedge clk)
    begin
        if (stall_on && stall_left == 0 && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 6);
        if (stall_left > 0)
        begin
            stall_next = 1'b1;
            stall_left--;
        end
        else
        begin
            stall_next = 1'b0;
        end
        if (!stall_on)
        begin
            stall_next = 1'b0;
            stall_left = 0;
        end
        result_stall <= stall_next;
    end

    task send_item(input twel_pkg::twel_cmd_t cmd, input logic [31:0] now);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid  <= 1'b1;
        command     <= cmd;
        now_seconds <= now;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
    endtask

    // wait until every expected result is back, then let the pipeline empty
    task settle();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task write_window(input logic [31:0] w);
        cfg_write_data <= w;
        cfg_write_en   <= 1'b1;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        sb.set_window(w);
        window_count++;
        @(negedge clk);
    endtask

    task fill_log(inout logic [31:0] t);
        int extra;
        while (sb.held < LOG_DEPTH)
        begin
            t += $urandom_range(0, 3);
            send_item(twel_pkg::CMD_RECORD, t);
        end
        extra = $urandom_range(1, 3);
        repeat (extra) send_item(twel_pkg::CMD_RECORD, $urandom);
    endtask

    task run_timeline(inout logic [31:0] t, input int len);
        int unsigned span;
        int          pick;
        span = (sb.window > 2000) ? 2000 : sb.window + 3;
        repeat (len)
        begin
            if ($urandom_range(0, 7) == 0)
                t += sb.window + $urandom_range(1, 50);
            else
                t += $urandom_range(0, span);
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_item(twel_pkg::CMD_RECORD, t);
            else if (pick < 92)
                send_item(twel_pkg::CMD_PRUNE, t);
            else if (pick < 96)
                send_item(twel_pkg::CMD_CLEAR, t);
            else
                send_item(CMD_NOOP, t);
        end
    endtask

    task run_noise(input int len);
        repeat (len) send_item(twel_pkg::twel_cmd_t'($urandom_range(0, 3)), $urandom);
    endtask

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [31:0] t;
        logic [31:0] win;
        int          start;
        int          kind;
        bit          paused;

        sb             = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        item_valid     = 1'b0;
        command        = twel_pkg::CMD_RECORD;
        now_seconds    = '0;
        result_stall   = 1'b0;
        stall_left     = 0;
        gaps_on        = 1'b1;
        stall_on       = 1'b1;
        window_count   = 1;
        paused         = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default window: empty prune, zero stamp, boundary of the expiry test
        send_item(twel_pkg::CMD_PRUNE, 32'd1000);
        send_item(twel_pkg::CMD_RECORD, 32'd0);
        send_item(twel_pkg::CMD_RECORD, 32'd100);
        send_item(twel_pkg::CMD_PRUNE, 32'd59);
        send_item(twel_pkg::CMD_PRUNE, 32'd60);
        send_item(twel_pkg::CMD_PRUNE, 32'd61);
        send_item(twel_pkg::CMD_PRUNE, 32'd160);
        send_item(twel_pkg::CMD_PRUNE, 32'd161);
        send_item(twel_pkg::CMD_PRUNE, 32'd5000);
        send_item(CMD_NOOP, 32'hFFFF_FFFF);
        send_item(twel_pkg::CMD_RECORD, 32'hFFFF_FFFF);
        send_item(twel_pkg::CMD_RECORD, 32'h8000_0000);
        send_item(twel_pkg::CMD_CLEAR, 32'd0);
        send_item(CMD_NOOP, 32'd0);
        settle();
        write_window(32'd0);
        send_item(twel_pkg::CMD_RECORD, 32'd0);
        send_item(twel_pkg::CMD_PRUNE, 32'd0);
        send_item(twel_pkg::CMD_PRUNE, 32'd1);
        send_item(twel_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
        settle();
        write_window(32'hFFFF_FFFF);
        send_item(twel_pkg::CMD_RECORD, 32'd0);
        send_item(twel_pkg::CMD_PRUNE, 32'hFFFF_FFFE);
        send_item(twel_pkg::CMD_PRUNE, 32'hFFFF_FFFF);
        settle();
        write_window(32'hFFFF_FFFE);
        send_item(twel_pkg::CMD_PRUNE, 32'hFFFF_FFFF);

        for (int ph = 0; ph < 8; ph++)
        begin
            settle();
            case (ph)
                0: win = 32'd1;
                1: win = 32'hFFFF_FFFF;
                2: win = 32'd0;
                3: win = $urandom_range(10, 500);
                4: win = $urandom;
                5: win = 32'd60;
                6: win = $urandom_range(0, 50);
                default: win = $urandom_range(20, 300);
            endcase
            write_window(win);
            gaps_on  = (ph != 5 && ph != 7);
            stall_on = gaps_on;
            t        = win + $urandom_range(0, 100);
            start    = sb.items;
            if (ph == 0 || ph == 5)
                fill_log(t);
            while (sb.items - start < PHASE_ITEMS)
            begin
                if (ph == 3 && !paused && sb.items - start > PHASE_ITEMS / 2)
                begin
                    settle();
                    paused = 1'b1;
                end
                kind = $urandom_range(0, 19);
                if (kind < 14)
                    run_timeline(t, $urandom_range(5, 20));
                else if (kind < 15)
                    fill_log(t);
                else
                    run_noise($urandom_range(3, 10));
            end
        end

        settle();
        if (sb.pending() != 0)
            sb.report_mismatch("expected results left over", sb.pending(), 0);
        $display("covered %0d items and %0d results over %0d window settings",
                 sb.items, sb.results, window_count);
        $display("refused records seen: %0d, prunes seen: %0d", sb.drops, sb.prunes);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
